// File: design/bfss_pkg.sv
// shared types and constants of the bloom filter string set unit
`timescale 1ns / 1ps
package bfss_pkg;

  // one queued byte of a string
  typedef struct packed {
    logic       func;
    logic [7:0] char_byte;
    logic       last_byte;
  } bfss_item_t;

  localparam int FuncLookup = 0;
  localparam int FuncInsert = 1;

  localparam int Mul37     = 37;
  localparam int Mul17     = 17;
  localparam int Mul11     = 11;
  localparam int Mul9      = 9;
  localparam int Start37   = 8;
  localparam int StartSum  = 0;
  localparam int Start17   = 1;
  localparam int Start11   = 4;
  localparam int StartPow  = 1;
  localparam int CfgWidth  = 13;
  localparam int SizeReset = 4096;

endpackage

// File: design/bfss_front.sv
// front end: input acceptance and a two-entry byte queue
`timescale 1ns / 1ps
module bfss_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                hold,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [7:0]          in_char_byte,
  input  logic                in_last_byte,
  output logic                item_valid,
  input  logic                item_ready,
  output bfss_pkg::bfss_item_t item
);

  bfss_pkg::bfss_item_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready   = (cnt_r != 2'd2) && !hold;
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{func: in_func, char_byte: in_char_byte, last_byte: in_last_byte};
    end
  end

endmodule

// File: design/bfss_modred.sv
// bit-serial remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module bfss_modred #(
  parameter int XW = 22,
  parameter int SW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [XW-1:0] x,
  input  logic [SW-1:0] s,
  output logic          busy,
  output logic [SW-1:0] rem
);

  localparam int CW = $clog2(XW + 1);

  logic [XW-1:0] x_r, x_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [SW:0]   trial;

  assign busy = busy_r;
  assign rem  = rem_r;

  always_comb begin
    trial    = {rem_r, x_r[XW-1]};
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      x_nxt    = x;
      rem_nxt  = '0;
      cnt_nxt  = CW'(XW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt = {x_r[XW-2:0], 1'b0};
      if (trial >= {1'b0, s}) begin
        rem_nxt = SW'(trial - {1'b0, s});
      end else begin
        rem_nxt = trial[SW-1:0];
      end
      cnt_nxt  = cnt_r - CW'(1);
      busy_nxt = (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// File: design/bfss_back.sv
// back end: running hashes, filter bit store and result register
`timescale 1ns / 1ps
module bfss_back #(
  parameter int FILTER_BITS = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [$clog2(FILTER_BITS + 1)-1:0]    live_size,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  bfss_pkg::bfss_item_t                  item,
  output logic                                  clearing,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_answer
);

  localparam int HW = $clog2(FILTER_BITS);
  localparam int SW = $clog2(FILTER_BITS + 1);
  localparam int XW = SW + 9;

  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StRed  = 3'd3;
  localparam logic [2:0] StRd   = 3'd4;
  localparam logic [2:0] StWr   = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]    state_r, state_nxt;
  bfss_pkg::bfss_item_t item_r;
  logic [SW-1:0] s_r;
  logic [SW-1:0] h37_r, h37_nxt, hsum_r, hsum_nxt, h17_r, h17_nxt, h11_r, h11_nxt;
  logic [SW-1:0] p17_r, p17_nxt, p11_r, p11_nxt;
  logic [7:0]    fb_r, fb_nxt, fbv;
  logic          first_r, first_nxt;
  logic [HW-1:0] idx_r [4];
  logic [HW-1:0] clr_r, clr_nxt;
  logic [2:0]    k_r, k_nxt;
  logic          all_r, all_nxt, all_fin;
  logic          rd_pend_r;
  logic          ans_r, ans_nxt;
  logic          out_valid_r, out_valid_nxt, out_answer_r, out_load;
  logic          mem_we, mem_wd;
  logic [HW-1:0] mem_wa;
  logic          mem [FILTER_BITS];
  logic          rd_q_r;
  logic [XW-1:0] x_c [6];
  logic [SW-1:0] r_w [6];
  logic [5:0]    busy_w;
  logic          red_start;

  assign item_ready = (state_r == StIdle);
  assign clearing   = (state_r == StClr);
  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;
  assign red_start  = (state_r == StMul);
  assign fbv        = first_r ? item_r.char_byte : fb_r;
  assign all_fin    = all_r & rd_q_r;

  // each term is formed combinationally, then fed into its remainder unit
  always_comb begin
    x_c[0] = XW'(h37_r) * XW'(bfss_pkg::Mul37) + XW'(item_r.char_byte);
    x_c[1] = XW'(hsum_r) + XW'(item_r.char_byte);
    x_c[2] = XW'(h17_r) + XW'(p17_r) * XW'(item_r.char_byte);
    x_c[3] = XW'(h11_r) * XW'(bfss_pkg::Mul9) + XW'(fbv) * XW'(p11_r);
    x_c[4] = XW'(p17_r) * XW'(bfss_pkg::Mul17);
    x_c[5] = XW'(p11_r) * XW'(bfss_pkg::Mul11);
  end

  for (genvar g = 0; g < 6; g++) begin : g_red
    bfss_modred #(.XW(XW), .SW(SW)) u_red (
      .clk   (clk),
      .rst_n (rst_n),
      .start (red_start),
      .x     (x_c[g]),
      .s     (s_r),
      .busy  (busy_w[g]),
      .rem   (r_w[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    h37_nxt   = h37_r;
    hsum_nxt  = hsum_r;
    h17_nxt   = h17_r;
    h11_nxt   = h11_r;
    p17_nxt   = p17_r;
    p11_nxt   = p11_r;
    fb_nxt    = fb_r;
    first_nxt = first_r;
    clr_nxt   = clr_r;
    k_nxt     = k_r;
    all_nxt   = all_r;
    ans_nxt   = ans_r;
    mem_we    = 1'b0;
    mem_wd    = 1'b0;
    mem_wa    = idx_r[k_r[1:0]];
    out_load  = 1'b0;
    case (state_r)
      StClr: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + HW'(1);
        if (clr_r == HW'(FILTER_BITS - 1)) begin
          state_nxt = StIdle;
        end
      end
      StIdle: begin
        if (item_valid) begin
          state_nxt = StMul;
        end
      end
      StMul: begin
        state_nxt = StRed;
      end
      StRed: begin
        if (busy_w == 6'd0) begin
          h37_nxt   = r_w[0];
          hsum_nxt  = r_w[1];
          h17_nxt   = r_w[2];
          h11_nxt   = r_w[3];
          p17_nxt   = r_w[4];
          p11_nxt   = r_w[5];
          fb_nxt    = fbv;
          first_nxt = 1'b0;
          state_nxt = StIdle;
          if (item_r.last_byte) begin
            h37_nxt   = SW'(bfss_pkg::Start37);
            hsum_nxt  = SW'(bfss_pkg::StartSum);
            h17_nxt   = SW'(bfss_pkg::Start17);
            h11_nxt   = SW'(bfss_pkg::Start11);
            p17_nxt   = SW'(bfss_pkg::StartPow);
            p11_nxt   = SW'(bfss_pkg::StartPow);
            fb_nxt    = 8'd0;
            first_nxt = 1'b1;
            k_nxt     = 3'd0;
            all_nxt   = 1'b1;
            state_nxt = StRd;
          end
        end
      end
      StRd: begin
        if (rd_pend_r) begin
          all_nxt = all_fin;
        end
        if (k_r != 3'd4) begin
          k_nxt = k_r + 3'd1;
        end else begin
          k_nxt = 3'd0;
          if (item_r.func == 1'(bfss_pkg::FuncInsert) && !all_fin) begin
            state_nxt = StWr;
          end else begin
            ans_nxt   = (item_r.func == 1'(bfss_pkg::FuncInsert)) ? 1'b0 : all_fin;
            state_nxt = StOut;
          end
        end
      end
      StWr: begin
        mem_we = 1'b1;
        mem_wd = 1'b1;
        k_nxt  = k_r + 3'd1;
        if (k_r == 3'd3) begin
          ans_nxt   = 1'b1;
          state_nxt = StOut;
        end
      end
      StOut: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StClr;
      clr_r       <= '0;
      k_r         <= 3'd0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      h37_r       <= SW'(bfss_pkg::Start37);
      hsum_r      <= SW'(bfss_pkg::StartSum);
      h17_r       <= SW'(bfss_pkg::Start17);
      h11_r       <= SW'(bfss_pkg::Start11);
      p17_r       <= SW'(bfss_pkg::StartPow);
      p11_r       <= SW'(bfss_pkg::StartPow);
      fb_r        <= 8'd0;
      first_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      k_r         <= k_nxt;
      rd_pend_r   <= (state_r == StRd) && (k_r != 3'd4);
      out_valid_r <= out_valid_nxt;
      h37_r       <= h37_nxt;
      hsum_r      <= hsum_nxt;
      h17_r       <= h17_nxt;
      h11_r       <= h11_nxt;
      p17_r       <= p17_nxt;
      p11_r       <= p11_nxt;
      fb_r        <= fb_nxt;
      first_r     <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    all_r <= all_nxt;
    ans_r <= ans_nxt;
    if (item_valid && item_ready) begin
      item_r <= item;
      s_r    <= live_size;
    end
    if (state_r == StRed && busy_w == 6'd0 && item_r.last_byte) begin
      idx_r[0] <= r_w[0][HW-1:0];
      idx_r[1] <= r_w[1][HW-1:0];
      idx_r[2] <= r_w[2][HW-1:0];
      idx_r[3] <= r_w[3][HW-1:0];
    end
    if (out_load) begin
      out_answer_r <= ans_r;
    end
  end

  // filter bit store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q_r <= mem[idx_r[k_r[1:0]]];
  end

endmodule

// File: design/bloom_filter_string_set_unit.sv
// top level of the bloom filter string set unit
// per byte: a byte passes the multiply state and then the bit-serial remainder units; a
//   last byte then reads its four filter bits from the store, sets all four on an insert
//   that finds one clear, and loads the result register
// flow: the back end takes one byte at a time; the queue takes two bytes ahead of the back end
// reset: synchronous active-low; afterwards the bit store is swept to zero with in_ready
//   low, configuration writes are taken throughout
`timescale 1ns / 1ps
module bloom_filter_string_set_unit #(
  parameter int FILTER_BITS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_table_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_char_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_answer
);

  localparam int SW = $clog2(FILTER_BITS + 1);

  logic [bfss_pkg::CfgWidth-1:0] size_r, size_nxt;
  logic [SW-1:0]                 live_size;
  logic                          clearing;
  logic                          item_valid, item_ready;
  bfss_pkg::bfss_item_t          item;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_comb begin
    size_nxt = size_r;
    if (cfg_valid && cfg_ready) begin
      size_nxt = cfg_table_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= bfss_pkg::CfgWidth'(bfss_pkg::SizeReset);
    end else begin
      size_r <= size_nxt;
    end
  end

  // effective modulus: zero acts as one, clamp to the store size
  always_comb begin
    if (size_r == '0) begin
      live_size = SW'(1);
    end else if (32'(size_r) > FILTER_BITS) begin
      live_size = SW'(FILTER_BITS);
    end else begin
      live_size = SW'(size_r);
    end
  end

  // front end: accepts bytes into a short queue
  bfss_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .hold         (clearing),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_char_byte (in_char_byte),
    .in_last_byte (in_last_byte),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item)
  );

  // back end: hash update, store access and result register
  bfss_back #(.FILTER_BITS(FILTER_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .live_size  (live_size),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_answer (out_answer)
  );

  // no transaction is taken while the store is being swept
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("input accepted during store sweep");

  // modulus always within the store
  a_live_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    (live_size != '0) && (32'(live_size) <= FILTER_BITS))
    else $error("effective size out of range");

  // back end takes one byte at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && item_ready) |=> !item_ready)
    else $error("back end took a second byte while busy");

endmodule
